@@ hdl/v3au_pkg.sv @@
// Package for the three-component vector arithmetic unit: beat types,
// command codes, pipeline sizes and the rounding and saturation helpers.
// No dependencies.
package v3au_pkg;

   localparam int WORD_BITS   = 32;                 // saturation range of results
   localparam int FRAC_BITS   = 16;                 // fraction bits of Q format
   localparam int FIELD_BITS  = 32;                 // width of every payload word
   localparam int PROD_BITS   = 2 * FIELD_BITS;     // exact product
   localparam int ACC_BITS    = PROD_BITS + 2;      // sum of three products
   localparam int SQ_BITS     = PROD_BITS;          // sum of squares, unsigned
   localparam int ROOT_BITS   = SQ_BITS / 2;
   localparam int REM_BITS    = ROOT_BITS + 2;
   localparam int MAG_BITS    = ROOT_BITS + 1;      // rounded root may carry
   localparam int QUO_BITS    = FRAC_BITS + 1;      // unit vector component <= 1.0
   localparam int NUM_BITS    = FIELD_BITS + FRAC_BITS;
   localparam int DIV_W       = MAG_BITS + FRAC_BITS + 1;
   localparam int SQRT_STAGES = ROOT_BITS;
   localparam int DIV_DEPTH   = QUO_BITS + 1;
   localparam int LANES       = 3;
   localparam int PIPE_DEPTH  = 5 + SQRT_STAGES + 1 + DIV_DEPTH + 1;

   localparam logic signed [ACC_BITS-1:0] SAT_MAX =
      (ACC_BITS'(1) <<< (WORD_BITS - 1)) - ACC_BITS'(1);
   localparam logic signed [ACC_BITS-1:0] SAT_MIN = -SAT_MAX - ACC_BITS'(1);
   localparam logic signed [ACC_BITS-1:0] RND_HALF = ACC_BITS'(1) <<< (FRAC_BITS - 1);

   typedef enum logic [2:0] {
      CMD_ADD       = 3'd0,
      CMD_SCALE     = 3'd1,
      CMD_NEGATE    = 3'd2,
      CMD_DOT       = 3'd3,
      CMD_CROSS     = 3'd4,
      CMD_MAGNITUDE = 3'd5,
      CMD_NORMALIZE = 3'd6
   } cmd_type;

   typedef struct packed {
      logic [2:0]                   command;
      logic signed [FIELD_BITS-1:0] ax;
      logic signed [FIELD_BITS-1:0] ay;
      logic signed [FIELD_BITS-1:0] az;
      logic signed [FIELD_BITS-1:0] bx;
      logic signed [FIELD_BITS-1:0] by_comp;
      logic signed [FIELD_BITS-1:0] bz;
      logic signed [FIELD_BITS-1:0] scale;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] rx;
      logic signed [FIELD_BITS-1:0] ry;
      logic signed [FIELD_BITS-1:0] rz;
      logic signed [FIELD_BITS-1:0] scalar_out;
      logic                         zero_length;
   } rsp_type;

   // operands handed to one lane
   typedef struct packed {
      logic signed [FIELD_BITS-1:0] a;
      logic signed [FIELD_BITS-1:0] b;
      logic signed [FIELD_BITS-1:0] s;
      logic signed [FIELD_BITS-1:0] c1a;
      logic signed [FIELD_BITS-1:0] c1b;
      logic signed [FIELD_BITS-1:0] c2a;
      logic signed [FIELD_BITS-1:0] c2b;
   } lane_ops_type;

   function automatic logic [FIELD_BITS-1:0] sat_word(input logic signed [ACC_BITS-1:0] v);
      logic [FIELD_BITS-1:0] r;
      if (v > SAT_MAX)
         r = SAT_MAX[FIELD_BITS-1:0];
      else if (v < SAT_MIN)
         r = SAT_MIN[FIELD_BITS-1:0];
      else
         r = v[FIELD_BITS-1:0];
      return r;
   endfunction

   // round to nearest, ties toward plus infinity
   function automatic logic signed [ACC_BITS-1:0] round_frac(
      input logic signed [ACC_BITS-1:0] v);
      return (v + RND_HALF) >>> FRAC_BITS;
   endfunction

endpackage

@@ hdl/vec3_arith_unit.sv @@
// Top level of the three-component vector arithmetic unit: three lanes,
// merge stage, square root pipeline, three divider lanes and output register.
// Depends on v3au_pkg, v3au_lane, v3au_sqrt and v3au_div.
//
//   channel   ports                         beat
//   --------  ----------------------------  -------------------------------
//   request   req_valid req_ready req_data  command, vectors A and B, scale
//   response  rsp_valid rsp_ready rsp_data  vector, scalar, zero_length
//
// One beat per cycle while no response beat is held; every command passes
// through the whole pipeline, including the 32-stage square root and the
// 18-stage divider that normalize needs.
// The pipeline moves as one: it stalls only while the output register holds
// a beat that is not taken, and req_ready follows that.
// Reset clears the valid bits only; no clearing pass.
module vec3_arith_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  v3au_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output v3au_pkg::rsp_type rsp_data
);
   import v3au_pkg::*;

   typedef struct packed {
      logic [2:0]                  command;
      logic [2:0][FIELD_BITS-1:0]  vec;      // result, or |A| for normalize
      logic [FIELD_BITS-1:0]       scalar;
      logic [2:0]                  neg;      // sign of A for normalize
      logic                        zero_length;
   } side_type;

   logic                         adv;
   logic [PIPE_DEPTH-1:0]        valid_ff, valid_in;

   // lanes (stages 1..3)
   lane_ops_type                 ops [LANES];
   logic signed [ACC_BITS-1:0]   lane_val [LANES];
   logic signed [FIELD_BITS-1:0] lane_a [LANES];
   logic [2:0]                   cmd1_ff, cmd2_ff, cmd3_ff;

   // merge (stage 4) and scalar round (stage 5)
   logic [2:0]                   cmd4_ff;
   logic signed [ACC_BITS-1:0]   tot_in, tot4_ff;
   logic [2:0][FIELD_BITS-1:0]   vec_in, vec4_ff;
   logic [2:0]                   neg_in, neg4_ff;
   side_type                     side5_in, side5_ff;
   logic [SQ_BITS-1:0]           sq5_ff;

   // root, rounding (stage 38), divide, output
   logic [ROOT_BITS-1:0]         root;
   logic [REM_BITS-1:0]          root_rem;
   side_type                     side_sq_ff [SQRT_STAGES];
   side_type                     side38_in, side38_ff;
   logic [MAG_BITS-1:0]          mag_in, mag38_ff;
   side_type                     side_dv_ff [DIV_DEPTH];
   logic [QUO_BITS-1:0]          quo [LANES];
   rsp_type                      rsp_in, rsp_ff;

   assign adv       = !valid_ff[PIPE_DEPTH-1] || rsp_ready;
   assign req_ready = adv;
   assign valid_in  = {valid_ff[PIPE_DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= '0;
      else if (adv)
         valid_ff <= valid_in;
   end

   // cross product pairs: x = ay*bz - az*by, y = az*bx - ax*bz, z = ax*by - ay*bx
   always_comb begin
      ops[0] = '{a: req_data.ax, b: req_data.bx, s: req_data.scale,
                 c1a: req_data.ay, c1b: req_data.bz, c2a: req_data.az, c2b: req_data.by_comp};
      ops[1] = '{a: req_data.ay, b: req_data.by_comp, s: req_data.scale,
                 c1a: req_data.az, c1b: req_data.bx, c2a: req_data.ax, c2b: req_data.bz};
      ops[2] = '{a: req_data.az, b: req_data.bz, s: req_data.scale,
                 c1a: req_data.ax, c1b: req_data.by_comp, c2a: req_data.ay, c2b: req_data.bx};
   end

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      v3au_lane u_lane (
         .clock   (clock),
         .adv     (adv),
         .command (req_data.command),
         .ops     (ops[i]),
         .val     (lane_val[i]),
         .a_out   (lane_a[i])
      );
   end

   // merge: lane sum for dot, magnitude and normalize, per-lane round and clamp
   always_comb begin
      logic [FIELD_BITS-1:0] abs_a;
      tot_in = lane_val[0] + lane_val[1] + lane_val[2];
      for (int i = 0; i < LANES; i++) begin
         neg_in[i] = lane_a[i][FIELD_BITS-1];
         abs_a     = neg_in[i] ? FIELD_BITS'(-lane_a[i]) : FIELD_BITS'(lane_a[i]);
         case (cmd_type'(cmd3_ff)) inside
            CMD_ADD, CMD_NEGATE:  vec_in[i] = sat_word(lane_val[i]);
            CMD_SCALE, CMD_CROSS: vec_in[i] = sat_word(round_frac(lane_val[i]));
            CMD_NORMALIZE:        vec_in[i] = abs_a;
            default:              vec_in[i] = '0;
         endcase
      end
   end

   always_comb begin
      side5_in.command     = cmd4_ff;
      side5_in.vec         = vec4_ff;
      side5_in.neg         = neg4_ff;
      side5_in.zero_length = 1'b0;
      side5_in.scalar      = (cmd4_ff == CMD_DOT) ? sat_word(round_frac(tot4_ff)) : '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cmd1_ff  <= req_data.command;
         cmd2_ff  <= cmd1_ff;
         cmd3_ff  <= cmd2_ff;
         cmd4_ff  <= cmd3_ff;
         tot4_ff  <= tot_in;
         vec4_ff  <= vec_in;
         neg4_ff  <= neg_in;
         side5_ff <= side5_in;
         sq5_ff   <= tot4_ff[SQ_BITS-1:0];
      end
   end

   v3au_sqrt u_sqrt (
      .clock (clock),
      .adv   (adv),
      .sq    (sq5_ff),
      .root  (root),
      .rem   (root_rem)
   );

   // round root to nearest: bump when remainder exceeds root
   always_comb begin
      mag_in    = MAG_BITS'(root) + MAG_BITS'(root_rem > REM_BITS'(root));
      side38_in = side_sq_ff[SQRT_STAGES-1];
      if (side38_in.command == CMD_MAGNITUDE)
         side38_in.scalar = sat_word(ACC_BITS'(mag_in));
      if (side38_in.command == CMD_NORMALIZE)
         side38_in.zero_length = (mag_in == '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_sq_ff[0] <= side5_ff;
         for (int k = 1; k < SQRT_STAGES; k++)
            side_sq_ff[k] <= side_sq_ff[k-1];
         side38_ff <= side38_in;
         mag38_ff  <= mag_in;
         side_dv_ff[0] <= side38_ff;
         for (int k = 1; k < DIV_DEPTH; k++)
            side_dv_ff[k] <= side_dv_ff[k-1];
         rsp_ff <= rsp_in;
      end
   end

   // |A|*2^F + m/2 over m gives round-half-away once the sign is put back
   for (genvar i = 0; i < LANES; i++) begin : g_div
      v3au_div u_div (
         .clock (clock),
         .adv   (adv),
         .num   ((NUM_BITS'(side38_ff.vec[i]) << FRAC_BITS)
                 + NUM_BITS'(mag38_ff >> 1)),
         .den   (mag38_ff),
         .quo   (quo[i])
      );
   end

   always_comb begin
      side_type                    sd;
      logic signed [ACC_BITS-1:0]  qext;
      logic [2:0][FIELD_BITS-1:0]  vo;
      sd = side_dv_ff[DIV_DEPTH-1];
      vo = sd.vec;
      for (int i = 0; i < LANES; i++) begin
         qext = signed'(ACC_BITS'(quo[i]));
         if (sd.command == CMD_NORMALIZE)
            vo[i] = sd.zero_length ? '0 : sat_word(sd.neg[i] ? -qext : qext);
      end
      rsp_in.rx          = vo[0];
      rsp_in.ry          = vo[1];
      rsp_in.rz          = vo[2];
      rsp_in.scalar_out  = sd.scalar;
      rsp_in.zero_length = sd.zero_length;
   end

   assign rsp_valid = valid_ff[PIPE_DEPTH-1];
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   // square root remainder never exceeds twice the root
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[4 + SQRT_STAGES] |-> root_rem <= {1'b0, root, 1'b0})
      else $error("sqrt remainder out of range");

   // a zero-length normalize carries an all-zero result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_length |->
         rsp_data.rx == '0 && rsp_data.ry == '0 && rsp_data.rz == '0
         && rsp_data.scalar_out == '0)
      else $error("zero_length beat with nonzero fields");

   // the request side stalls only behind a held response beat
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without a held response");
`endif

endmodule

@@ hdl/v3au_lane.sv @@
// One vector lane: operand select, two signed multipliers and the lane
// combine (add, negate, product, cross difference). Three stages.
// Depends on v3au_pkg.
module v3au_lane (
   input  logic                                  clock,
   input  logic                                  adv,
   input  logic [2:0]                            command,
   input  v3au_pkg::lane_ops_type                ops,
   output logic signed [v3au_pkg::ACC_BITS-1:0]  val,
   output logic signed [v3au_pkg::FIELD_BITS-1:0] a_out
);
   import v3au_pkg::*;

   logic [2:0]                   cmd1_ff, cmd2_ff;
   logic signed [FIELD_BITS-1:0] a1_ff, b1_ff, a2_ff, b2_ff, a3_ff;
   logic signed [FIELD_BITS-1:0] m1a_in, m1b_in, m1a_ff, m1b_ff, m2a_ff, m2b_ff;
   logic signed [PROD_BITS-1:0]  p1_in, p2_in, p1_ff, p2_ff;
   logic signed [ACC_BITS-1:0]   val_in, val_ff;

   always_comb begin
      m1a_in = ops.a;
      m1b_in = ops.a;
      case (cmd_type'(command))
         CMD_SCALE: m1b_in = ops.s;
         CMD_DOT:   m1b_in = ops.b;
         CMD_CROSS: begin
            m1a_in = ops.c1a;
            m1b_in = ops.c1b;
         end
         default: m1b_in = ops.a;
      endcase
   end

   assign p1_in = PROD_BITS'(m1a_ff) * PROD_BITS'(m1b_ff);
   assign p2_in = PROD_BITS'(m2a_ff) * PROD_BITS'(m2b_ff);

   always_comb begin
      case (cmd_type'(cmd2_ff)) inside
         CMD_ADD:    val_in = ACC_BITS'(a2_ff) + ACC_BITS'(b2_ff);
         CMD_NEGATE: val_in = -ACC_BITS'(a2_ff);
         CMD_CROSS:  val_in = ACC_BITS'(p1_ff) - ACC_BITS'(p2_ff);
         CMD_SCALE, CMD_DOT, CMD_MAGNITUDE, CMD_NORMALIZE: val_in = ACC_BITS'(p1_ff);
         default:    val_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cmd1_ff <= command;
         a1_ff   <= ops.a;
         b1_ff   <= ops.b;
         m1a_ff  <= m1a_in;
         m1b_ff  <= m1b_in;
         m2a_ff  <= ops.c2a;
         m2b_ff  <= ops.c2b;
         cmd2_ff <= cmd1_ff;
         a2_ff   <= a1_ff;
         b2_ff   <= b1_ff;
         p1_ff   <= p1_in;
         p2_ff   <= p2_in;
         a3_ff   <= a2_ff;
         val_ff  <= val_in;
      end
   end

   assign val   = val_ff;
   assign a_out = a3_ff;

endmodule

@@ hdl/v3au_sqrt.sv @@
// Pipelined integer square root, two radicand bits per stage, leaving
// floor root and remainder. Depends on v3au_pkg.
module v3au_sqrt (
   input  logic                              clock,
   input  logic                              adv,
   input  logic [v3au_pkg::SQ_BITS-1:0]      sq,
   output logic [v3au_pkg::ROOT_BITS-1:0]    root,
   output logic [v3au_pkg::REM_BITS-1:0]     rem
);
   import v3au_pkg::*;

   logic [SQ_BITS-1:0]   s_ff [SQRT_STAGES];
   logic [REM_BITS-1:0]  r_ff [SQRT_STAGES];
   logic [ROOT_BITS-1:0] q_ff [SQRT_STAGES];
   logic [SQ_BITS-1:0]   s_in [SQRT_STAGES];
   logic [REM_BITS-1:0]  r_in [SQRT_STAGES];
   logic [ROOT_BITS-1:0] q_in [SQRT_STAGES];

   always_comb begin
      logic [SQ_BITS-1:0]    cur_s;
      logic [REM_BITS-1:0]   cur_r;
      logic [ROOT_BITS-1:0]  cur_q;
      logic [REM_BITS+1:0]   trial, tq;
      logic                  ge;
      for (int k = 0; k < SQRT_STAGES; k++) begin
         if (k == 0) begin
            cur_s = sq;
            cur_r = '0;
            cur_q = '0;
         end else begin
            cur_s = s_ff[k-1];
            cur_r = r_ff[k-1];
            cur_q = q_ff[k-1];
         end
         trial   = {cur_r, cur_s[SQ_BITS-1 -: 2]};
         tq      = {2'b00, cur_q, 2'b01};
         ge      = trial >= tq;
         r_in[k] = ge ? REM_BITS'(trial - tq) : REM_BITS'(trial);
         q_in[k] = {cur_q[ROOT_BITS-2:0], ge};
         s_in[k] = cur_s << 2;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < SQRT_STAGES; k++) begin
            s_ff[k] <= s_in[k];
            r_ff[k] <= r_in[k];
            q_ff[k] <= q_in[k];
         end
      end
   end

   assign root = q_ff[SQRT_STAGES-1];
   assign rem  = r_ff[SQRT_STAGES-1];

endmodule

@@ hdl/v3au_div.sv @@
// Pipelined restoring divider, one quotient bit per stage after the load
// stage, for the normalize lanes. Depends on v3au_pkg.
module v3au_div (
   input  logic                             clock,
   input  logic                             adv,
   input  logic [v3au_pkg::NUM_BITS-1:0]    num,
   input  logic [v3au_pkg::MAG_BITS-1:0]    den,
   output logic [v3au_pkg::QUO_BITS-1:0]    quo
);
   import v3au_pkg::*;

   logic [DIV_W-1:0]    n_ff [DIV_DEPTH];
   logic [MAG_BITS-1:0] d_ff [DIV_DEPTH];
   logic [QUO_BITS-1:0] q_ff [DIV_DEPTH];
   logic [DIV_W-1:0]    n_in [DIV_DEPTH];
   logic [QUO_BITS-1:0] q_in [DIV_DEPTH];

   always_comb begin
      logic [DIV_W-1:0] sub;
      logic             ge;
      n_in[0] = DIV_W'(num);
      q_in[0] = '0;
      for (int j = 1; j < DIV_DEPTH; j++) begin
         sub     = DIV_W'(d_ff[j-1]) << (QUO_BITS - j);
         ge      = n_ff[j-1] >= sub;
         n_in[j] = ge ? n_ff[j-1] - sub : n_ff[j-1];
         q_in[j] = {q_ff[j-1][QUO_BITS-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff[0] <= den;
         for (int j = 1; j < DIV_DEPTH; j++)
            d_ff[j] <= d_ff[j-1];
         for (int j = 0; j < DIV_DEPTH; j++) begin
            n_ff[j] <= n_in[j];
            q_ff[j] <= q_in[j];
         end
      end
   end

   assign quo = q_ff[DIV_DEPTH-1];

endmodule
